// ===== hdl/sine_commutation_duty_calc_core_defines.svh =====
// Assertion macros shared by the commutation duty calculator RTL.
`ifndef SINE_COMMUTATION_DUTY_CALC_CORE_DEFINES_SVH
`define SINE_COMMUTATION_DUTY_CALC_CORE_DEFINES_SVH

// Clocked assertion, masked while reset is high.
`define SCDC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SCDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/scdc_pkg.sv =====
// Types and constants for the sinusoidal commutation duty calculator.
package scdc_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 2048;
   localparam int NUM_TABLES          = 6;
   localparam int NUM_PHASES          = 3;

   // field widths
   localparam int ANG_W    = 11;
   localparam int PWM_W    = 12;
   localparam int INDUC_W  = 17;
   localparam int BAT_W    = 12;
   localparam int TSEL_W   = 3;
   localparam int TVAL_W   = 12;
   localparam int DUTY_W   = 10;
   localparam int MID_W    = 10;

   // request tdata layout, lowest bit first
   localparam int ANG_LSB   = 0;
   localparam int PWM_LSB   = ANG_LSB + ANG_W;
   localparam int INDUC_LSB = PWM_LSB + PWM_W;
   localparam int CRIT_LSB  = INDUC_LSB + INDUC_W;
   localparam int POLE_LSB  = CRIT_LSB + 1;
   localparam int BAT_LSB   = POLE_LSB + 1;
   localparam int TSEL_LSB  = BAT_LSB + BAT_W;
   localparam int TVAL_LSB  = TSEL_LSB + TSEL_W;
   localparam int REQ_BITS  = TVAL_LSB + TVAL_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_BITS    = NUM_PHASES * DUTY_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = MID_W;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEASURE_RESISTANCE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PWM_MIDPOINT       = 1'd1;
   localparam logic [MID_W-1:0]      PWM_MIDPOINT_RESET     = 10'd500;

   typedef enum logic {
      REQ_COMMUTATE = 1'b0,
      REQ_WRITE     = 1'b1
   } req_kind_type;

   typedef enum logic [TSEL_W-1:0] {
      TBL_SIN_A = 3'd0,
      TBL_SIN_B = 3'd1,
      TBL_SIN_C = 3'd2,
      TBL_COS_A = 3'd3,
      TBL_COS_B = 3'd4,
      TBL_COS_C = 3'd5
   } tbl_sel_type;

   // duty limits
   localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd989;
   localparam logic [DUTY_W-1:0] DUTY_MIN = 10'd1;

   // normal mode scaling: divide by 1024, toward zero
   localparam int DUTY_SHIFT = 10;

   // resistance-mode battery curve
   localparam int BV_OFFSET   = 302;
   localparam int BV_GAIN     = 33;
   localparam int BV_SHIFT    = 7;
   localparam int LIN_GAIN    = 170;
   localparam int LIN_SHIFT   = 8;
   localparam int SQ_DIVISOR  = 979;
   localparam int RES_BIAS    = 190;
   localparam int RES_OFF_MAX = 150;

   // reciprocal constants: floor(x/d) = (x*M) >> K, exact over the input range
   localparam int          DIV3_K = 18;
   localparam longint      DIV3_M = (64'd1 << DIV3_K) / 3 + 1;
   localparam int          SQD_K  = 35;
   localparam longint      SQD_M  = (64'd1 << SQD_K) / SQ_DIVISOR + 1;

endpackage

// ===== hdl/sine_commutation_duty_calc_core.sv =====
// Sinusoidal three-phase commutation duty calculator, pipelined top level.
//
// Request channel (req_*): one item per accepted beat. tuser carries the kind:
// commutate or table write. A table write stores table_value at entry ang of
// the table chosen by table_select (selects above cosine C are dropped) and
// gives no response. A commutate request with pole_search_active set gives no
// response either. Every other commutate request gives one response beat
// (rsp_*) with the three phase duties, each in 1..989.
// A response reaches rsp_tvalid through six register stages (table read,
// multiply, sum, scale, mode select, clamp register).
// Throughput: one request per cycle while a low rsp_tready does not stall
// the stages; each table is a memory with one write and one registered
// read port.
// A request may follow a write to the same entry in the next cycle.
// Each stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up while rsp_tready is low; the stage
// registers hold their data until the response is taken.
// Reset clears the stage valid bits and the registers (resistance mode off,
// midpoint 500); table contents are undefined until written. The user must
// write the csr_* port only while no request is in flight; the block does not enforce this.
`include "sine_commutation_duty_calc_core_defines.svh"

module sine_commutation_duty_calc_core #(
   parameter int TABLE_DEPTH = scdc_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // ang, pwm, induc_weight, critical_error, pole_search_active, battery_raw,
   // table_select, table_value, zero fill
   input  logic [scdc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // duty_a, duty_b, duty_c, zero fill
   output logic [scdc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [scdc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [scdc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import scdc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // ---------------------------------------------------------------- registers
   logic              measure_res_ff, measure_res_in;
   logic [MID_W-1:0]  midpoint_ff, midpoint_in;

   always_comb begin
      measure_res_in = measure_res_ff;
      midpoint_in    = midpoint_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MEASURE_RESISTANCE: measure_res_in = csr_wdata[0];
            CSR_PWM_MIDPOINT:       midpoint_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measure_res_ff <= 1'b0;
         midpoint_ff    <= PWM_MIDPOINT_RESET;
      end else begin
         measure_res_ff <= measure_res_in;
         midpoint_ff    <= midpoint_in;
      end
   end

   // ---------------------------------------------------------------- unpack
   logic [ANG_W-1:0]          req_ang;
   logic signed [PWM_W-1:0]   req_pwm;
   logic signed [INDUC_W-1:0] req_induc;
   logic                      req_crit;
   logic                      req_pole;
   logic [BAT_W-1:0]          req_bat;
   logic [TSEL_W-1:0]         req_tsel;
   logic signed [TVAL_W-1:0]  req_tval;

   assign req_ang   = req_tdata[ANG_LSB +: ANG_W];
   assign req_pwm   = req_tdata[PWM_LSB +: PWM_W];
   assign req_induc = req_tdata[INDUC_LSB +: INDUC_W];
   assign req_crit  = req_tdata[CRIT_LSB];
   assign req_pole  = req_tdata[POLE_LSB];
   assign req_bat   = req_tdata[BAT_LSB +: BAT_W];
   assign req_tsel  = req_tdata[TSEL_LSB +: TSEL_W];
   assign req_tval  = req_tdata[TVAL_LSB +: TVAL_W];

   // ---------------------------------------------------------------- stage control
   logic v_s1_ff, v_s2_ff, v_s3_ff, v_s4_ff, v_s5_ff, rsp_tvalid_ff;
   logic en_s1, en_s2, en_s3, en_s4, en_s5, en_out;
   logic req_fire, tbl_we, v_s1_in;

   assign en_out = !rsp_tvalid_ff || rsp_tready;
   assign en_s5  = !v_s5_ff || en_out;
   assign en_s4  = !v_s4_ff || en_s5;
   assign en_s3  = !v_s3_ff || en_s4;
   assign en_s2  = !v_s2_ff || en_s3;
   assign en_s1  = !v_s1_ff || en_s2;

   assign req_tready = en_s1;
   assign req_fire   = req_tvalid && req_tready;
   assign tbl_we     = req_fire && (req_tuser == REQ_WRITE) && (req_tsel <= TBL_COS_C);
   assign v_s1_in    = req_fire && (req_tuser == REQ_COMMUTATE) && !req_pole;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_s1_ff       <= 1'b0;
         v_s2_ff       <= 1'b0;
         v_s3_ff       <= 1'b0;
         v_s4_ff       <= 1'b0;
         v_s5_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (en_s1)  v_s1_ff       <= v_s1_in;
         if (en_s2)  v_s2_ff       <= v_s1_ff;
         if (en_s3)  v_s3_ff       <= v_s2_ff;
         if (en_s4)  v_s4_ff       <= v_s3_ff;
         if (en_s5)  v_s5_ff       <= v_s4_ff;
         if (en_out) rsp_tvalid_ff <= v_s5_ff;
      end
   end

   // ---------------------------------------------------------------- table index
   logic [IDX_W-1:0] tbl_idx;

   generate
      if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0 || TABLE_DEPTH >= (1 << ANG_W)) begin : g_idx_direct
         assign tbl_idx = IDX_W'(req_ang);
      end else begin : g_idx_wrap
         // ang mod depth by reciprocal; exact for 11-bit angles
         localparam int          WRAP_K = 24;
         localparam longint      WRAP_M = (64'd1 << WRAP_K) / TABLE_DEPTH + 1;
         logic [ANG_W+WRAP_K-1:0] wrap_prod;
         logic [ANG_W-1:0]        wrap_quo;
         logic [ANG_W-1:0]        wrap_rem;
         assign wrap_prod = (ANG_W+WRAP_K)'(req_ang) * (ANG_W+WRAP_K)'(WRAP_M);
         assign wrap_quo  = wrap_prod[ANG_W+WRAP_K-1:WRAP_K];
         assign wrap_rem  = req_ang - ANG_W'(wrap_quo * ANG_W'(TABLE_DEPTH));
         assign tbl_idx   = IDX_W'(wrap_rem);
      end
   endgenerate

   // ---------------------------------------------------------------- stage 1: tables
   logic signed [TVAL_W-1:0] rd_s1_ff [NUM_TABLES];

   generate
      for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
         logic signed [TVAL_W-1:0] tbl_mem [TABLE_DEPTH];
         always_ff @(posedge clock) begin
            if (tbl_we && req_tsel == TSEL_W'(t)) tbl_mem[tbl_idx] <= req_tval;
            if (en_s1) rd_s1_ff[t] <= tbl_mem[tbl_idx];
         end
      end
   endgenerate

   logic                      crit_s1_ff;
   logic signed [PWM_W-1:0]   pwm_s1_ff;
   logic signed [INDUC_W-1:0] induc_s1_ff;
   logic [14:0]               bq_s1_ff, bq_s1_in;
   logic [BAT_W+4+DIV3_K-1:0] div3_prod;

   // 16*bat/3
   assign div3_prod = (BAT_W+4+DIV3_K)'({req_bat, 4'b0000}) * (BAT_W+4+DIV3_K)'(DIV3_M);
   assign bq_s1_in  = div3_prod[DIV3_K +: 15];

   always_ff @(posedge clock) begin
      if (en_s1) begin
         crit_s1_ff  <= req_crit;
         pwm_s1_ff   <= req_pwm;
         induc_s1_ff <= req_induc;
         bq_s1_ff    <= bq_s1_in;
      end
   end

   // ---------------------------------------------------------------- stage 2: products
   logic                             crit_s2_ff;
   logic signed [PWM_W+TVAL_W-1:0]   ps_s2_ff [NUM_PHASES];
   logic signed [PWM_W+TVAL_W-1:0]   ps_s2_in [NUM_PHASES];
   logic signed [INDUC_W+TVAL_W-1:0] pc_s2_ff [NUM_PHASES];
   logic signed [INDUC_W+TVAL_W-1:0] pc_s2_in [NUM_PHASES];
   logic [12:0]                      bv_s2_ff, bv_s2_in;
   logic [19:0]                      bv_scaled;

   always_comb begin
      for (int p = 0; p < NUM_PHASES; p++) begin
         ps_s2_in[p] = rd_s1_ff[p] * pwm_s1_ff;
         pc_s2_in[p] = rd_s1_ff[p + NUM_PHASES] * induc_s1_ff;
      end
   end

   assign bv_scaled = (20'(bq_s1_ff) + 20'(BV_OFFSET)) * 20'(BV_GAIN);
   assign bv_s2_in  = bv_scaled[BV_SHIFT +: 13];

   always_ff @(posedge clock) begin
      if (en_s2) begin
         crit_s2_ff <= crit_s1_ff;
         ps_s2_ff   <= ps_s2_in;
         pc_s2_ff   <= pc_s2_in;
         bv_s2_ff   <= bv_s2_in;
      end
   end

   // ---------------------------------------------------------------- stage 3: sums
   localparam int SUM_W = INDUC_W + TVAL_W + 1;

   logic                    crit_s3_ff;
   logic signed [SUM_W-1:0] sum_s3_ff [NUM_PHASES];
   logic signed [SUM_W-1:0] sum_s3_in [NUM_PHASES];
   logic [25:0]             sq_s3_ff, sq_s3_in;
   logic [11:0]             lin_s3_ff, lin_s3_in;
   logic [20:0]             lin_prod;

   always_comb begin
      for (int p = 0; p < NUM_PHASES; p++) begin
         sum_s3_in[p] = {{(SUM_W-PWM_W-TVAL_W){ps_s2_ff[p][PWM_W+TVAL_W-1]}}, ps_s2_ff[p]}
                      + {pc_s2_ff[p][INDUC_W+TVAL_W-1], pc_s2_ff[p]};
      end
   end

   assign sq_s3_in  = 26'(bv_s2_ff) * 26'(bv_s2_ff);
   assign lin_prod  = 21'(bv_s2_ff) * 21'(LIN_GAIN);
   assign lin_s3_in = lin_prod[LIN_SHIFT +: 12];

   always_ff @(posedge clock) begin
      if (en_s3) begin
         crit_s3_ff <= crit_s2_ff;
         sum_s3_ff  <= sum_s3_in;
         sq_s3_ff   <= sq_s3_in;
         lin_s3_ff  <= lin_s3_in;
      end
   end

   // ---------------------------------------------------------------- stage 4: scale
   localparam int QUO_W = SUM_W - DUTY_SHIFT;

   logic                    crit_s4_ff;
   logic signed [QUO_W-1:0] quo_s4_ff [NUM_PHASES];
   logic signed [QUO_W-1:0] quo_s4_in [NUM_PHASES];
   logic [15:0]             sqd_s4_ff, sqd_s4_in;
   logic [11:0]             lin_s4_ff;
   logic [26+SQD_K-10:0]    sqd_prod;
   logic signed [SUM_W-1:0] biased [NUM_PHASES];

   // bias negatives by 1023 so the shift truncates toward zero
   always_comb begin
      for (int p = 0; p < NUM_PHASES; p++) begin
         biased[p]    = sum_s3_ff[p] + (sum_s3_ff[p][SUM_W-1] ?
                        SUM_W'((1 << DUTY_SHIFT) - 1) : SUM_W'(0));
         quo_s4_in[p] = biased[p][SUM_W-1:DUTY_SHIFT];
      end
   end

   assign sqd_prod  = (26+SQD_K-9)'(sq_s3_ff) * (26+SQD_K-9)'(SQD_M);
   assign sqd_s4_in = sqd_prod[SQD_K +: 16];

   always_ff @(posedge clock) begin
      if (en_s4) begin
         crit_s4_ff <= crit_s3_ff;
         quo_s4_ff  <= quo_s4_in;
         sqd_s4_ff  <= sqd_s4_in;
         lin_s4_ff  <= lin_s3_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5: mode select
   logic signed [QUO_W-1:0] pre_s5_ff [NUM_PHASES];
   logic signed [QUO_W-1:0] pre_s5_in [NUM_PHASES];
   logic signed [17:0]      res_off;
   logic [7:0]              res_off_sat;

   always_comb begin
      res_off = $signed({2'b00, sqd_s4_ff}) - $signed({6'd0, lin_s4_ff}) + 18'sd190;
      if (res_off > 18'(RES_OFF_MAX)) begin
         res_off_sat = 8'(RES_OFF_MAX);
      end else if (res_off < 18'sd0) begin
         res_off_sat = 8'd0;
      end else begin
         res_off_sat = res_off[7:0];
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (crit_s4_ff) begin
            pre_s5_in[p] = '0;
         end else if (measure_res_ff) begin
            pre_s5_in[p] = (p == 0) ? QUO_W'(res_off_sat) : '0;
         end else begin
            pre_s5_in[p] = quo_s4_ff[p];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_s5) pre_s5_ff <= pre_s5_in;
   end

   // ---------------------------------------------------------------- output: midpoint + clamp
   logic [DUTY_W-1:0]        duty_ff [NUM_PHASES];
   logic [DUTY_W-1:0]        duty_in [NUM_PHASES];
   logic signed [QUO_W:0]    duty_raw [NUM_PHASES];

   always_comb begin
      for (int p = 0; p < NUM_PHASES; p++) begin
         duty_raw[p] = {pre_s5_ff[p][QUO_W-1], pre_s5_ff[p]}
                     + $signed({{(QUO_W+1-MID_W){1'b0}}, midpoint_ff});
         if (duty_raw[p] > $signed({{(QUO_W+1-DUTY_W){1'b0}}, DUTY_MAX})) begin
            duty_in[p] = DUTY_MAX;
         end else if (duty_raw[p] < $signed({{(QUO_W+1-DUTY_W){1'b0}}, DUTY_MIN})) begin
            duty_in[p] = DUTY_MIN;
         end else begin
            duty_in[p] = duty_raw[p][DUTY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) duty_ff <= duty_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_BITS){1'b0}}, duty_ff[2], duty_ff[1], duty_ff[0]};

   // ---------------------------------------------------------------- assertions
   `SCDC_ASSERT(a_write_no_rsp, clock, reset, (req_fire && req_tuser == REQ_WRITE) |=> !v_s1_ff, "table write request entered the pipeline")
   `SCDC_ASSERT(a_pole_no_rsp, clock, reset, (req_fire && req_pole) |=> !v_s1_ff, "pole search request entered the pipeline")
   `SCDC_ASSERT(a_duty_range, clock, reset, rsp_tvalid_ff |-> (duty_ff[0] >= DUTY_MIN && duty_ff[0] <= DUTY_MAX && duty_ff[1] >= DUTY_MIN && duty_ff[1] <= DUTY_MAX && duty_ff[2] >= DUTY_MIN && duty_ff[2] <= DUTY_MAX), "duty outside clamp range")
   `SCDC_ASSERT(a_s5_hold, clock, reset, (v_s5_ff && !en_s5) |=> (v_s5_ff && $stable(pre_s5_ff[0]) && $stable(pre_s5_ff[1]) && $stable(pre_s5_ff[2])), "stalled stage lost its request")
   `SCDC_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> (!v_s1_ff && !v_s5_ff && !rsp_tvalid_ff), "pipeline not empty after reset")

endmodule
